/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers used by the port-level checker of the tone sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/mts_pkg.sv */
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types, codes and the melody ROM of the tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Field widths
  localparam int TclkW    = 24;
  localparam int TpmW     = 16;
  localparam int HpW      = 16;
  localparam int MsW      = 16;
  localparam int FreqW    = 11;
  localparam int DurW     = 8;
  localparam int DivisorW = FreqW + 1;
  localparam int NoteW    = 3;
  localparam int MelW     = 3;
  localparam int LenW     = 4;

  // Cap on notes played from any melody
  localparam int MaxNotes = 8;

  // Command codes
  localparam logic [1:0] CmdTick = 2'd0;
  localparam logic [1:0] CmdPlay = 2'd1;
  localparam logic [1:0] CmdStop = 2'd2;

  // Configuration register indexes
  localparam logic CfgTimerClockHz = 1'b0;
  localparam logic CfgTicksPerMs   = 1'b1;

  localparam logic [MelW-1:0] NumMelodies = 3'd5;

  localparam logic [TclkW-1:0] TimerClockHzReset = 24'd2000000;
  localparam logic [TpmW-1:0]  TicksPerMsReset   = 16'd2000;

  // Melody ROM: frequency in Hz (0 = rest), duration in ms, length
  localparam logic [FreqW-1:0] FreqRom [5][8] = '{
    '{11'd800,  11'd1000, 11'd1200, 11'd1000, 11'd0,    11'd0, 11'd0, 11'd0},
    '{11'd1000, 11'd1200, 11'd0,    11'd0,    11'd0,    11'd0, 11'd0, 11'd0},
    '{11'd1200, 11'd0,    11'd0,    11'd0,    11'd0,    11'd0, 11'd0, 11'd0},
    '{11'd1000, 11'd1200, 11'd0,    11'd0,    11'd0,    11'd0, 11'd0, 11'd0},
    '{11'd1200, 11'd0,    11'd1200, 11'd0,    11'd1200, 11'd0, 11'd0, 11'd0}
  };

  localparam logic [DurW-1:0] DurRom [5][8] = '{
    '{8'd100, 8'd100, 8'd120, 8'd250, 8'd50,  8'd0, 8'd0, 8'd0},
    '{8'd70,  8'd110, 8'd30,  8'd0,   8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd45,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd100, 8'd180, 8'd0,   8'd0,   8'd0,   8'd0, 8'd0, 8'd0},
    '{8'd100, 8'd70,  8'd100, 8'd70,  8'd100, 8'd0, 8'd0, 8'd0}
  };

  localparam logic [LenW-1:0] LenRom [5] = '{4'd5, 4'd3, 4'd1, 4'd2, 4'd5};

  // Controller to datapath
  typedef struct packed {
    logic apply;      // apply the accepted input beat to the state
    logic div_start;  // launch the half-period division
    logic load_hp;    // store the division result
  } mts_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;   // the incoming beat starts a tone note
    logic div_done;   // quotient ready
  } mts_sts_t;

  function automatic logic [FreqW-1:0] note_freq(input logic [MelW-1:0] mel,
                                                 input logic [NoteW-1:0] idx);
    logic [FreqW-1:0] f;
    f = '0;
    if (mel < NumMelodies) f = FreqRom[mel][idx];
    return f;
  endfunction

  function automatic logic [DurW-1:0] note_dur(input logic [MelW-1:0] mel,
                                               input logic [NoteW-1:0] idx);
    logic [DurW-1:0] d;
    d = '0;
    if (mel < NumMelodies) d = DurRom[mel][idx];
    return d;
  endfunction

  function automatic logic [LenW-1:0] melody_len(input logic [MelW-1:0] mel);
    logic [LenW-1:0] n;
    n = '0;
    if (mel < NumMelodies) n = LenRom[mel];
    if (int'(n) > MaxNotes) n = LenW'(MaxNotes);
    return n;
  endfunction

endpackage

/* hw/rtl/mts_channels.sv */
// ----------------------------------------------------------------------------
// mts_channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface mts_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] event_req;

  modport source (output valid, output command, output event_req, input ready);
  modport sink   (input valid, input command, input event_req, output ready);
endinterface

interface mts_res_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic       busy_res;
  logic       tone_on;
  logic [2:0] note_number;

  modport source (output valid, output pin_level, output busy_res, output tone_on,
                  output note_number, input ready);
  modport sink   (input valid, input pin_level, input busy_res, input tone_on,
                  input note_number, output ready);
endinterface

/* hw/rtl/mts_divider.sv */
// ----------------------------------------------------------------------------
// mts_divider
// Restoring divider, one quotient bit per cycle, result clamped to 1..65535.
// ----------------------------------------------------------------------------
module mts_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [mts_pkg::TclkW-1:0]      dividend,
  input  logic [mts_pkg::DivisorW-1:0]   divisor,
  output logic                           done,
  output logic [mts_pkg::HpW-1:0]        quotient
);
  import mts_pkg::*;

  localparam int CntW = $clog2(TclkW);

  logic                 run;
  logic [CntW-1:0]      count;
  logic [DivisorW-1:0]  rem;
  logic [TclkW-1:0]     quo;
  logic [DivisorW-1:0]  dvsr;
  logic [DivisorW:0]    shifted;
  logic                 fits;

  // One restoring step
  assign shifted = {rem, quo[TclkW-1]};
  assign fits    = shifted >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      // pulse once the last quotient bit lands
      done <= run && !start && (count == '0);
      if (start) begin
        run   <= 1'b1;
        count <= CntW'(TclkW - 1);
        rem   <= '0;
        quo   <= dividend;
        dvsr  <= divisor;
      end else if (run) begin
        rem   <= fits ? DivisorW'(shifted - {1'b0, dvsr}) : shifted[DivisorW-1:0];
        quo   <= {quo[TclkW-2:0], fits};
        count <= count - 1'b1;
        if (count == '0) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Clamp to the half-period range
  always_comb begin
    if (quo == '0) begin
      quotient = HpW'(1);
    end else if (quo[TclkW-1:HpW] != '0) begin
      quotient = '1;
    end else begin
      quotient = quo[HpW-1:0];
    end
  end

endmodule

/* hw/rtl/mts_datapath.sv */
// ----------------------------------------------------------------------------
// mts_datapath
// Sequencer state, tone and millisecond counters, config registers.
// ----------------------------------------------------------------------------
module mts_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  mts_pkg::mts_cmd_t           ctl,
  output mts_pkg::mts_sts_t           sts,
  input  logic [1:0]                  command,
  input  logic [2:0]                  event_req,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mts_pkg::TclkW-1:0]   cfg_data,
  output logic                        pin_level,
  output logic                        busy_res,
  output logic                        tone_on,
  output logic [2:0]                  note_number
);
  import mts_pkg::*;

  // Configuration
  logic [TclkW-1:0] timer_clock_hz;
  logic [TpmW-1:0]  ticks_per_ms;

  // Sequencer state
  logic             busy_flag,     busy_flag_next;
  logic [MelW-1:0]  melody_select, melody_select_next;
  logic [NoteW-1:0] note_index,    note_index_next;
  logic [MsW-1:0]   elapsed_ms,    elapsed_ms_next;
  logic [TpmW-1:0]  ms_prescaler,  ms_prescaler_next;
  logic [HpW-1:0]   half_period;
  logic [HpW-1:0]   tone_counter,  tone_counter_next;
  logic             tone_enable,   tone_enable_next;
  logic             pin_state,     pin_state_next;

  logic [HpW-1:0]   tc_inc;
  logic [TpmW-1:0]  mp_inc;
  logic [TpmW-1:0]  tpm_eff;
  logic [MsW-1:0]   elapsed_inc;
  logic [LenW-1:0]  note_inc;
  logic             start_note;
  logic [FreqW-1:0] new_freq;
  logic             need_div;
  logic             div_done;
  logic [HpW-1:0]   div_q;

  assign tc_inc      = tone_counter + 1'b1;
  assign mp_inc      = ms_prescaler + 1'b1;
  assign tpm_eff     = (ticks_per_ms == '0) ? TpmW'(1) : ticks_per_ms;
  assign elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 1'b1;
  assign note_inc    = {1'b0, note_index} + 1'b1;

  // Next state for the incoming beat
  always_comb begin
    busy_flag_next     = busy_flag;
    melody_select_next = melody_select;
    note_index_next    = note_index;
    elapsed_ms_next    = elapsed_ms;
    ms_prescaler_next  = ms_prescaler;
    tone_counter_next  = tone_counter;
    tone_enable_next   = tone_enable;
    pin_state_next     = pin_state;
    start_note         = 1'b0;
    need_div           = 1'b0;
    new_freq           = '0;

    unique case (command)
      CmdTick: begin
        if (busy_flag) begin
          // tone counter first
          if (tone_enable) begin
            if (tc_inc >= half_period) begin
              pin_state_next    = ~pin_state;
              tone_counter_next = '0;
            end else begin
              tone_counter_next = tc_inc;
            end
          end
          // then the millisecond count
          if (mp_inc < tpm_eff) begin
            ms_prescaler_next = mp_inc;
          end else begin
            ms_prescaler_next = '0;
            elapsed_ms_next   = elapsed_inc;
            if (elapsed_inc >= MsW'(note_dur(melody_select, note_index))) begin
              if (note_inc >= melody_len(melody_select)) begin
                // end of melody
                busy_flag_next     = 1'b0;
                melody_select_next = '0;
                note_index_next    = '0;
                elapsed_ms_next    = '0;
                ms_prescaler_next  = '0;
                tone_counter_next  = '0;
                tone_enable_next   = 1'b0;
                pin_state_next     = 1'b0;
              end else begin
                note_index_next = note_inc[NoteW-1:0];
                elapsed_ms_next = '0;
                start_note      = 1'b1;
              end
            end
          end
        end
      end
      CmdPlay: begin
        if (event_req < NumMelodies) begin
          melody_select_next = event_req;
          note_index_next    = '0;
          elapsed_ms_next    = '0;
          ms_prescaler_next  = '0;
          busy_flag_next     = 1'b1;
          start_note         = 1'b1;
        end
      end
      CmdStop: begin
        busy_flag_next     = 1'b0;
        melody_select_next = '0;
        note_index_next    = '0;
        elapsed_ms_next    = '0;
        ms_prescaler_next  = '0;
        tone_counter_next  = '0;
        tone_enable_next   = 1'b0;
        pin_state_next     = 1'b0;
      end
      default: begin
        // unused command: no change
      end
    endcase

    // note start: pin low, counter cleared, division for a tone
    if (start_note) begin
      new_freq          = note_freq(melody_select_next, note_index_next);
      tone_counter_next = '0;
      pin_state_next    = 1'b0;
      tone_enable_next  = (new_freq != '0);
      need_div          = (new_freq != '0);
    end
  end

  // Half-period division: timer_clock_hz / (2 * freq)
  mts_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (timer_clock_hz),
    .divisor  ({new_freq, 1'b0}),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.need_div = need_div;
  assign sts.div_done = div_done;

  // State and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_clock_hz <= TimerClockHzReset;
      ticks_per_ms   <= TicksPerMsReset;
      busy_flag      <= 1'b0;
      melody_select  <= '0;
      note_index     <= '0;
      elapsed_ms     <= '0;
      ms_prescaler   <= '0;
      half_period    <= HpW'(1);
      tone_counter   <= '0;
      tone_enable    <= 1'b0;
      pin_state      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgTimerClockHz: timer_clock_hz <= cfg_data;
          CfgTicksPerMs:   ticks_per_ms   <= cfg_data[TpmW-1:0];
        endcase
      end
      if (ctl.apply) begin
        busy_flag     <= busy_flag_next;
        melody_select <= melody_select_next;
        note_index    <= note_index_next;
        elapsed_ms    <= elapsed_ms_next;
        ms_prescaler  <= ms_prescaler_next;
        tone_counter  <= tone_counter_next;
        tone_enable   <= tone_enable_next;
        pin_state     <= pin_state_next;
      end
      if (ctl.load_hp) begin
        half_period <= div_q;
      end
    end
  end

  // Result fields come straight from the state
  assign pin_level   = pin_state;
  assign busy_res    = busy_flag;
  assign tone_on     = busy_flag & tone_enable;
  assign note_number = note_index;

endmodule

/* hw/rtl/mts_ctrl.sv */
// ----------------------------------------------------------------------------
// mts_ctrl
// Beat sequencing: accept, wait for the divider, present the result.
// ----------------------------------------------------------------------------
module mts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  mts_pkg::mts_sts_t sts,
  output mts_pkg::mts_cmd_t ctl
);
  import mts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t state;
  logic   accept;

  // Take a new beat while idle, once the result slot is free or draining
  assign cmd_ready = (state == S_IDLE) && (!res_valid || res_ready);
  assign accept    = cmd_valid && cmd_ready;

  assign ctl.apply     = accept;
  assign ctl.div_start = accept && sts.need_div;
  assign ctl.load_hp   = (state == S_DIV) && sts.div_done;

  // State and result-valid register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (sts.need_div) begin
              state     <= S_DIV;
              res_valid <= 1'b0;
            end else begin
              res_valid <= 1'b1;
            end
          end else if (res_ready) begin
            res_valid <= 1'b0;
          end
        end
        S_DIV: begin
          if (sts.div_done) begin
            state     <= S_IDLE;
            res_valid <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/melody_tone_sequencer.sv */
// ----------------------------------------------------------------------------
// melody_tone_sequencer
// Five-melody square-wave buzzer sequencer driven by tick/play/stop beats.
// ----------------------------------------------------------------------------
// Results: a beat that starts no tone note gives its result in the cycle after
// it is taken; a tone note's result waits for the half-period divider, which
// takes one quotient bit per cycle over the 24-bit clock rate. One beat is
// in flight at a time; plain ticks go 1 per cycle while results are taken.
// Reset (rst, synchronous, active high) clears the sequencer state, the
// result slot and sets the configuration registers to their defaults.
module melody_tone_sequencer (
  input  logic                      clk,
  input  logic                      rst,
  mts_cmd_if.sink                   cmd_ch,
  mts_res_if.source                 res_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mts_pkg::TclkW-1:0] cfg_data
);
  import mts_pkg::*;

  mts_cmd_t ctl;
  mts_sts_t sts;

  mts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_ch.valid),
    .cmd_ready (cmd_ch.ready),
    .res_valid (res_ch.valid),
    .res_ready (res_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  mts_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (cmd_ch.command),
    .event_req   (cmd_ch.event_req),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pin_level   (res_ch.pin_level),
    .busy_res    (res_ch.busy_res),
    .tone_on     (res_ch.tone_on),
    .note_number (res_ch.note_number)
  );

endmodule

/* hw/rtl/mts_checker.sv */
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mts_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic       pin_level,
  input logic       busy_res,
  input logic       tone_on,
  input logic [2:0] note_number
);

  // A stalled result beat holds
  `ASSERT_CLK_RST(a_res_hold, clk, rst, res_valid && !res_ready |=> res_valid && $stable({pin_level, busy_res, tone_on, note_number}), "result beat changed while stalled")

  // No new command while an untaken result waits
  `ASSERT_CLK_RST(a_one_in_flight, clk, rst, res_valid && !res_ready |-> !(cmd_valid && cmd_ready), "command taken while result pending")

  // Idle sequencer shows a quiet pin at note zero
  `ASSERT_CLK_RST(a_idle_quiet, clk, rst, res_valid && !busy_res |-> !pin_level && !tone_on && note_number == 3'd0, "idle result not quiet")

  // Nothing is offered right after reset
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !res_valid, "result valid after reset")

endmodule

bind melody_tone_sequencer mts_checker u_mts_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_ch.valid),
  .cmd_ready   (cmd_ch.ready),
  .res_valid   (res_ch.valid),
  .res_ready   (res_ch.ready),
  .pin_level   (res_ch.pin_level),
  .busy_res    (res_ch.busy_res),
  .tone_on     (res_ch.tone_on),
  .note_number (res_ch.note_number)
);

/* bench/mts_checker.sv */
// ----------------------------------------------------------------------------
// mts_scoreboard
// Watches the command, result and register ports of the tone sequencer,
// tracks its own copy of the melody state and compares every result beat
// field by field with the state it expects after the matching command beat.
// ----------------------------------------------------------------------------
module mts_scoreboard (
  input  logic                      clk,
  input  logic                      rst,
  mts_cmd_if                        cmd_mon,
  mts_res_if                        res_mon,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mts_pkg::TclkW-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending_count
);
  import mts_pkg::*;

  localparam int SongCount = 5;

  // Melody table: tone in Hz (0 is a rest), length in ms, notes per melody
  localparam int NoteHz [5][8] = '{
    '{800,  1000, 1200, 1000, 0,    0, 0, 0},
    '{1000, 1200, 0,    0,    0,    0, 0, 0},
    '{1200, 0,    0,    0,    0,    0, 0, 0},
    '{1000, 1200, 0,    0,    0,    0, 0, 0},
    '{1200, 0,    1200, 0,    1200, 0, 0, 0}
  };
  localparam int NoteMs [5][8] = '{
    '{100, 100, 120, 250, 50,  0, 0, 0},
    '{70,  110, 30,  0,   0,   0, 0, 0},
    '{45,  0,   0,   0,   0,   0, 0, 0},
    '{100, 180, 0,   0,   0,   0, 0, 0},
    '{100, 70,  100, 70,  100, 0, 0, 0}
  };
  localparam int SongLen [5] = '{5, 3, 1, 2, 5};

  // One result beat as the buzzer should look after a command beat
  typedef struct packed {
    logic       pin;
    logic       busy;
    logic       tone;
    logic [2:0] note;
  } buzzer_view_t;

  buzzer_view_t buzzer_views[$];
  buzzer_view_t want;

  // Register copies
  logic [23:0] rate_hz;
  logic [15:0] ms_ticks;

  // Sequencer state
  logic        playing;
  logic [2:0]  song;
  logic [2:0]  note;
  logic [15:0] ms_count;
  logic [15:0] prescale;
  logic [15:0] half_per;
  logic [15:0] tone_cnt;
  logic        tone_live;
  logic        pin;

  int misses   = 0;
  int res_seen = 0;

  assign fail_count    = misses;
  assign pending_count = buzzer_views.size();

  task automatic report_mismatch(input string msg);
    if (misses < 100) $display("MISMATCH at result beat %0d: %s", res_seen, msg);
    misses++;
  endtask

  // Stop, end of melody and reset: everything idle, half-period kept
  task automatic silence();
    playing   = 1'b0;
    song      = '0;
    note      = '0;
    ms_count  = '0;
    prescale  = '0;
    tone_cnt  = '0;
    tone_live = 1'b0;
    pin       = 1'b0;
  endtask

  // Note start: pin low, counter cleared, half-period from the clock rate
  task automatic begin_note();
    int hz;
    int quot;
    hz       = NoteHz[song][note];
    tone_cnt = '0;
    pin      = 1'b0;
    if (hz == 0) begin
      tone_live = 1'b0;
    end else begin
      quot = int'(rate_hz) / (2 * hz);
      if (quot == 0) quot = 1;
      else if (quot > 65535) quot = 65535;
      half_per  = 16'(quot);
      tone_live = 1'b1;
    end
  endtask

  // One timer tick: tone counter first, then the millisecond count
  task automatic timer_tick();
    int limit;
    int len;
    if (!playing) return;
    if (tone_live) begin
      tone_cnt = tone_cnt + 16'd1;
      if (tone_cnt >= half_per) begin
        pin      = ~pin;
        tone_cnt = '0;
      end
    end
    limit    = (ms_ticks == '0) ? 1 : int'(ms_ticks);
    prescale = prescale + 16'd1;
    if (int'(prescale) < limit) return;
    prescale = '0;
    if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
    if (int'(ms_count) < NoteMs[song][note]) return;
    len = (SongLen[song] > MaxNotes) ? MaxNotes : SongLen[song];
    if (int'(note) + 1 >= len) begin
      silence();
      return;
    end
    note     = note + 3'd1;
    ms_count = '0;
    begin_note();
  endtask

  task automatic apply_beat(input logic [1:0] op, input logic [2:0] ev);
    case (op)
      CmdTick: timer_tick();
      CmdPlay: begin
        // unknown melody numbers are dropped
        if (int'(ev) < SongCount) begin
          song     = ev;
          note     = '0;
          ms_count = '0;
          prescale = '0;
          playing  = 1'b1;
          begin_note();
        end
      end
      CmdStop: silence();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rate_hz  = TimerClockHzReset;
      ms_ticks = TicksPerMsReset;
      silence();
      half_per = 16'd1;
      buzzer_views.delete();
    end else begin
      // the driver must write registers only while the block is idle; nothing here checks it
      if (cfg_we) begin
        if (cfg_index == CfgTimerClockHz) rate_hz = cfg_data[23:0];
        else ms_ticks = cfg_data[15:0];
      end

      // result beat against the oldest expectation
      if (res_mon.valid && res_mon.ready) begin
        if (buzzer_views.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = buzzer_views.pop_front();
          if (res_mon.pin_level !== want.pin)
            report_mismatch($sformatf("pin_level %b, want %b", res_mon.pin_level, want.pin));
          if (res_mon.busy_res !== want.busy)
            report_mismatch($sformatf("busy_res %b, want %b", res_mon.busy_res, want.busy));
          if (res_mon.tone_on !== want.tone)
            report_mismatch($sformatf("tone_on %b, want %b", res_mon.tone_on, want.tone));
          if (res_mon.note_number !== want.note)
            report_mismatch($sformatf("note_number %0d, want %0d",
                                      res_mon.note_number, want.note));
        end
        res_seen++;
      end

      // command beat: advance the state and queue what it should show
      if (cmd_mon.valid && cmd_mon.ready) begin
        apply_beat(cmd_mon.command, cmd_mon.event_req);
        buzzer_views.push_back('{pin: pin, busy: playing, tone: playing && tone_live,
                                 note: note});
      end
    end
  end

endmodule

/* bench/melody_tone_sequencer_test.sv */
// ----------------------------------------------------------------------------
// melody_tone_sequencer_test
// Drives tick, play and stop beats into the tone sequencer under a range of
// clock-rate and tick-per-ms settings, with random gaps and result stalls;
// a checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_test;
  import mts_pkg::*;

  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam int         PhaseCount  = 8;
  localparam int         PhaseBudget = 40;
  localparam int         CycleLimit  = 600000;

  // Total length of each melody in ms
  localparam int SongMs [5] = '{620, 210, 45, 280, 440};

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [TclkW-1:0]    cfg_data;
  int                  fail_count;
  int                  pending_count;

  mts_cmd_if cmd_ch ();
  mts_res_if res_ch ();

  // Stimulus bookkeeping
  logic calm = 1'b0;
  int   ready_wait = 0;
  int   cycle_count = 0;
  int   live_beats = 0;
  int   plays = 0;
  int   stops = 0;
  int   ticks = 0;
  int   ignored = 0;
  int   settings = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  melody_tone_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch.sink),
    .res_ch    (res_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mts_scoreboard u_scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cmd_mon       (cmd_ch),
    .res_mon       (res_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Result side: after each taken beat, stall by a random ready_wait unless calm
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_wait   <= 0;
    end else if (res_ch.ready && res_ch.valid) begin
      if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        ready_wait   <= $urandom_range(0, 6);
        res_ch.ready <= 1'b0;
      end
    end else if (!res_ch.ready) begin
      if (ready_wait <= 1) res_ch.ready <= 1'b1;
      else ready_wait <= ready_wait - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // One command beat, after a random gap; valid stays up when no gap follows
  task automatic send_beat(input logic [1:0] op, input logic [2:0] ev);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.command   <= op;
    cmd_ch.event_req <= ev;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    if (op == CmdUnused || (op == CmdPlay && ev > 3'd4)) begin
      ignored++;
    end else begin
      live_beats++;
      if (op == CmdPlay) plays++;
      else if (op == CmdStop) stops++;
      else ticks++;
    end
  endtask

  // Hold the command side until every result beat is back
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Both registers, back to back, on an idle block
  task automatic load_settings(input logic [23:0] hz, input logic [15:0] tpm);
    cfg_we    <= 1'b1;
    cfg_index <= CfgTimerClockHz;
    cfg_data  <= hz;
    @(posedge clk);
    cfg_index <= CfgTicksPerMs;
    cfg_data  <= TclkW'(tpm);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  // Start a melody and feed it timer ticks with random junk in event_req
  task automatic run_song(input logic [2:0] mel, input int tick_count);
    send_beat(CmdPlay, mel);
    repeat (tick_count) send_beat(CmdTick, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    logic [23:0] hz_list [PhaseCount];
    logic [15:0] tpm_list [PhaseCount];
    int          tpm_eff;
    int          stop_at;
    int          pick;
    int          span;
    logic [2:0]  mel;

    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CmdTick;
    cmd_ch.event_req = '0;
    cfg_we           = 1'b0;
    cfg_index        = CfgTimerClockHz;
    cfg_data         = '0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: every command and melody number at the reset settings
    calm = 1'b1;
    send_beat(CmdTick, 3'd0);
    send_beat(CmdStop, 3'd7);
    for (int e = 0; e < 8; e++) begin
      send_beat(CmdPlay, 3'(e));
      send_beat(CmdTick, 3'(7 - e));
    end
    send_beat(CmdUnused, 3'd7);
    send_beat(CmdPlay, 3'd2);
    send_beat(CmdUnused, 3'd0);
    send_beat(CmdPlay, 3'd6);
    send_beat(CmdTick, 3'd3);
    send_beat(CmdStop, 3'd0);
    send_beat(CmdTick, 3'd5);

    // Settings per phase; zero rate and zero ticks-per-ms come first
    hz_list  = '{24'd0, 24'd4800, 24'($urandom_range(1600, 40000)), 24'hFFFFFF,
                 24'($urandom_range(0, 40000)), 24'd1, 24'hFFFFFF,
                 24'($urandom_range(0, 24))};
    tpm_list = '{16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd2, 16'hFFFF,
                 16'($urandom_range(2, 5))};

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      repeat (30) @(posedge clk);
      load_settings(hz_list[p], tpm_list[p]);
      tpm_eff = (tpm_list[p] == '0) ? 1 : int'(tpm_list[p]);
      stop_at = live_beats + PhaseBudget;

      // fast phases open with one melody played to its end
      if (tpm_eff == 1 && p < 5) begin
        calm = 1'b0;
        run_song(3'(p), SongMs[p] + $urandom_range(0, 6));
      end

      while (live_beats < stop_at) begin
        calm = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          mel = 3'($urandom_range(0, 4));
          if (tpm_eff <= 2 && $urandom_range(0, 3) == 0)
            span = SongMs[mel] * tpm_eff + $urandom_range(0, 6);
          else
            span = $urandom_range(1, 90);
          run_song(mel, span);
          // end with a stop, a dead command, or let the next play cut in
          case ($urandom_range(0, 3))
            0: send_beat(CmdStop, 3'($urandom_range(0, 7)));
            1: send_beat(CmdUnused, 3'($urandom_range(0, 7)));
            default: ;
          endcase
        end else begin
          repeat ($urandom_range(1, 8))
            send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
        end
      end
    end

    drain_results();
    repeat (40) @(posedge clk);

    $display("Covered %0d command beats: %0d plays, %0d stops, %0d ticks, %0d ignored,",
             live_beats + ignored, plays, stops, ticks, ignored);
    $display("across %0d register settings including zero and all-ones values.",
             settings);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_channels.sv
hw/rtl/mts_divider.sv
hw/rtl/mts_datapath.sv
hw/rtl/mts_ctrl.sv
hw/rtl/melody_tone_sequencer.sv
hw/rtl/mts_checker.sv
bench/mts_checker.sv
bench/melody_tone_sequencer_test.sv
